[sv/irm_pkg.sv]
// shared types, field positions and constants for the i2c register master
package irm_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;

    // byte index of the byte being shifted out
    localparam logic [1:0] BYTE_DEV  = 2'd0;
    localparam logic [1:0] BYTE_REG  = 2'd1;
    localparam logic [1:0] BYTE_DATA = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // input word as it sits in tdata, lowest field last
    typedef struct packed {
        logic       sda_in;
        logic [7:0] burst_len;
        logic [7:0] wr_data;
        logic [7:0] sub_addr;
        logic [7:0] slave_addr;
        logic       func;
        logic       start_req;
    } t_in_word;

    // result word as it sits in tdata, lowest field last
    typedef struct packed {
        logic       error;
        logic       done_res;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       busy_res;
        logic       sda_out;
        logic       scl;
    } t_out_word;

    // classified tick held in the queue
    typedef struct packed {
        logic       start_req;
        logic       func;
        logic [7:0] slave_addr;
        logic [7:0] sub_addr;
        logic [7:0] wr_data;
        logic [7:0] burst_len;
        logic       sda_in;
    } t_tick;

    // queue head toward the back end
    typedef struct packed {
        logic  valid;
        t_tick tick;
    } t_q_head;

    typedef enum logic [16:0] {
        PH_IDLE   = 17'h00001,
        PH_START2 = 17'h00002,
        PH_WLOW   = 17'h00004,
        PH_WHIGH  = 17'h00008,
        PH_ALOW   = 17'h00010,
        PH_AHIGH  = 17'h00020,
        PH_RS1    = 17'h00040,
        PH_RS2    = 17'h00080,
        PH_RS3    = 17'h00100,
        PH_RS4    = 17'h00200,
        PH_RLOW   = 17'h00400,
        PH_RHIGH  = 17'h00800,
        PH_MLOW   = 17'h01000,
        PH_MHIGH  = 17'h02000,
        PH_STOP1  = 17'h04000,
        PH_STOP2  = 17'h08000,
        PH_STOP3  = 17'h10000
    } t_phase;

endpackage

[sv/irm_front.sv]
// front end: takes tick words, normalizes them and queues them for the bus engine
module irm_front
    import irm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_data,
    output t_q_head               o_head,
    input  logic                  i_pop
);

    t_tick                r_mem [QDEPTH];
    logic [QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]    r_count;
    t_in_word             w_in;
    t_tick                w_tick;
    logic                 w_push;
    logic                 w_pop;

    assign w_in    = t_in_word'(i_data[$bits(t_in_word)-1:0]);
    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_count != '0);

    // zero burst length reads one byte
    always_comb begin
        w_tick.start_req  = w_in.start_req;
        w_tick.func       = w_in.func;
        w_tick.slave_addr = w_in.slave_addr;
        w_tick.sub_addr   = w_in.sub_addr;
        w_tick.wr_data    = w_in.wr_data;
        w_tick.burst_len  = (w_in.burst_len == 8'd0) ? 8'd1 : w_in.burst_len;
        w_tick.sda_in     = w_in.sda_in;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.tick  = r_mem[r_rd_ptr];

endmodule

[sv/irm_back.sv]
// back end: i2c bus sequencer, one tick per cycle while the result word is not stalled, with registered result word
module irm_back
    import irm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_q_head                i_head,
    output logic                   o_pop,
    input  logic [15:0]            i_ack_timeout,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_data,
    output logic                   o_last
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [15:0] r_wait, n_wait;
    logic        r_func, n_func;
    logic [7:0]  r_dev, n_dev;
    logic [7:0]  r_reg, n_reg;
    logic [7:0]  r_data, n_data;
    logic [1:0]  r_byte_idx, n_byte_idx;
    logic        r_err, n_err;
    logic        r_out_valid;
    t_out_word   r_out, n_out;
    logic        r_out_last, n_out_last;

    logic        w_step;
    logic [15:0] w_lim;
    logic [15:0] w_wait_inc;
    logic [3:0]  w_bit_inc;
    logic [7:0]  w_rd_shift;
    logic        w_last_byte;
    t_tick       w_t;

    assign w_t         = i_head.tick;
    assign w_step      = i_head.valid && (!r_out_valid || i_ready);
    assign o_pop       = w_step;
    assign w_lim       = (i_ack_timeout == 16'd0) ? 16'd1 : i_ack_timeout;
    assign w_wait_inc  = r_wait + 16'd1;
    assign w_bit_inc   = r_bit_count + 4'd1;
    assign w_rd_shift  = {r_shift[6:0], w_t.sda_in};
    assign w_last_byte = (r_bytes_left <= 8'd1);

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_wait       = r_wait;
        n_func       = r_func;
        n_dev        = r_dev;
        n_reg        = r_reg;
        n_data       = r_data;
        n_byte_idx   = r_byte_idx;
        n_err        = r_err;
        n_out          = '0;
        n_out.scl      = 1'b1;
        n_out.sda_out  = 1'b1;
        n_out.busy_res = 1'b1;
        n_out_last     = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                n_out.busy_res = 1'b0;
                if (w_t.start_req) begin
                    n_func         = w_t.func;
                    n_dev          = w_t.slave_addr;
                    n_reg          = w_t.sub_addr;
                    n_data         = w_t.wr_data;
                    n_bytes_left   = w_t.burst_len;
                    n_err          = 1'b0;
                    n_out.busy_res = 1'b1;
                    n_out.sda_out  = 1'b0;
                    n_phase        = PH_START2;
                end
            end
            PH_START2: begin
                n_out.scl     = 1'b0;
                n_out.sda_out = 1'b0;
                n_shift       = r_dev;
                n_bit_count   = 4'd0;
                n_byte_idx    = BYTE_DEV;
                n_phase       = PH_WLOW;
            end
            PH_WLOW: begin
                n_out.scl     = 1'b0;
                n_out.sda_out = r_shift[7];
                n_phase       = PH_WHIGH;
            end
            PH_WHIGH: begin
                n_out.sda_out = r_shift[7];
                n_shift       = {r_shift[6:0], 1'b0};
                n_bit_count   = w_bit_inc;
                n_phase       = (w_bit_inc >= 4'd8) ? PH_ALOW : PH_WLOW;
            end
            PH_ALOW: begin
                n_out.scl = 1'b0;
                n_wait    = 16'd0;
                n_phase   = PH_AHIGH;
            end
            PH_AHIGH: begin
                if (!w_t.sda_in) begin
                    if (r_byte_idx == BYTE_DEV) begin
                        n_shift     = r_reg;
                        n_bit_count = 4'd0;
                        n_byte_idx  = BYTE_REG;
                        n_phase     = PH_WLOW;
                    end else if (r_byte_idx == BYTE_REG) begin
                        if (r_func == FUNC_READ) begin
                            n_phase = PH_RS1;
                        end else begin
                            n_shift     = r_data;
                            n_bit_count = 4'd0;
                            n_byte_idx  = BYTE_DATA;
                            n_phase     = PH_WLOW;
                        end
                    end else if (r_func == FUNC_READ) begin
                        n_shift     = 8'd0;
                        n_bit_count = 4'd0;
                        n_phase     = PH_RLOW;
                    end else begin
                        n_phase = PH_STOP1;
                    end
                end else begin
                    // counter wrap also aborts
                    n_wait = w_wait_inc;
                    if ((w_wait_inc >= w_lim) || (w_wait_inc == 16'd0)) begin
                        n_err   = 1'b1;
                        n_phase = PH_STOP1;
                    end
                end
            end
            PH_RS1: begin
                n_out.scl = 1'b0;
                n_phase   = PH_RS2;
            end
            PH_RS2: begin
                n_phase = PH_RS3;
            end
            PH_RS3: begin
                n_out.sda_out = 1'b0;
                n_phase       = PH_RS4;
            end
            PH_RS4: begin
                n_out.scl     = 1'b0;
                n_out.sda_out = 1'b0;
                n_shift       = r_dev + 8'd1;
                n_bit_count   = 4'd0;
                n_byte_idx    = BYTE_DATA;
                n_phase       = PH_WLOW;
            end
            PH_RLOW: begin
                n_out.scl = 1'b0;
                n_phase   = PH_RHIGH;
            end
            PH_RHIGH: begin
                n_shift     = w_rd_shift;
                n_bit_count = w_bit_inc;
                if (w_bit_inc >= 4'd8) begin
                    n_out.rd_valid = 1'b1;
                    n_out.rd_data  = w_rd_shift;
                    n_out_last     = w_last_byte;
                    n_phase        = PH_MLOW;
                end else begin
                    n_phase = PH_RLOW;
                end
            end
            PH_MLOW: begin
                n_out.scl     = 1'b0;
                n_out.sda_out = w_last_byte;
                n_phase       = PH_MHIGH;
            end
            PH_MHIGH: begin
                n_out.sda_out = w_last_byte;
                if (w_last_byte) begin
                    n_phase = PH_STOP1;
                end else begin
                    n_bytes_left = r_bytes_left - 8'd1;
                    n_shift      = 8'd0;
                    n_bit_count  = 4'd0;
                    n_phase      = PH_RLOW;
                end
            end
            PH_STOP1: begin
                n_out.scl     = 1'b0;
                n_out.sda_out = 1'b0;
                n_phase       = PH_STOP2;
            end
            PH_STOP2: begin
                n_out.sda_out = 1'b0;
                n_phase       = PH_STOP3;
            end
            PH_STOP3: begin
                n_out.done_res = 1'b1;
                n_out.error    = r_err;
                n_err          = 1'b0;
                n_phase        = PH_IDLE;
            end
            default: begin
                n_out.busy_res = 1'b0;
                n_phase        = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_bytes_left <= '0;
            r_wait       <= '0;
            r_byte_idx   <= BYTE_DEV;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_step) begin
                r_phase      <= n_phase;
                r_bit_count  <= n_bit_count;
                r_shift      <= n_shift;
                r_bytes_left <= n_bytes_left;
                r_wait       <= n_wait;
                r_byte_idx   <= n_byte_idx;
                r_err        <= n_err;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_func     <= n_func;
            r_dev      <= n_dev;
            r_reg      <= n_reg;
            r_data     <= n_data;
            r_out      <= n_out;
            r_out_last <= n_out_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = OUT_TDATA_W'(r_out);
    assign o_last  = r_out_last;

endmodule

[sv/i2c_register_master.sv]
// top level of the i2c register master: front queue, bus sequencer, timeout register
//
// i2c master for single register writes and register burst reads. every input word
// is one half-bit tick of the bus: it carries the sampled sda level and, while the
// bus is idle, a command (start_req, func, addresses, data, burst length). every
// input word yields exactly one result word with the scl and sda levels to drive on
// that tick plus busy, read byte, last, done and error flags. while m_axis takes every
// result, the block sustains one word per clock: a four-entry queue decouples the input
// side from the sequencer, and the sequencer steps its state machine once per word into
// an output register, so the result of a word passes through the queue and then the
// output register before it shows on m_axis. the queue
// depth and the output register alone set how long either side may stall before
// the other is throttled. ack_timeout (reset 1000, zero acts as one) counts high sda
// samples in an acknowledge slot; on expiry the bus gets a stop and done comes with
// error set. write ack_timeout only while no command is in flight.
module i2c_register_master
    import irm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input tick words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] start_req [1] func [9:2] slave_addr [17:10] sub_addr [25:18] wr_data
    // [33:26] burst_len [34] sda_in, rest zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] scl [1] sda_out [2] busy_res [3] rd_valid [11:4] rd_data [12] done_res
    // [13] error, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // rd_last: last byte of a read burst
    output logic                   m_axis_tlast,
    // ack_timeout register write
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_wdata
);

    logic [15:0] r_ack_timeout;
    t_q_head     w_head;
    logic        w_pop;

    // timeout register, applies immediately
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_ack_timeout <= i_cfg_wdata;
        end
    end

    // front: accept, normalize burst length, queue
    irm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // back: bus sequencer and result register
    irm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_ack_timeout (r_ack_timeout),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

endmodule

[sv/irm_checker.sv]
// port-level checks for the i2c register master, bound to the top level
module irm_checker
    import irm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    t_out_word w_out;
    assign w_out = t_out_word'(m_axis_tdata[$bits(t_out_word)-1:0]);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
        else $error("result word changed while stalled");

    // last byte flag only with a read byte
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> w_out.rd_valid)
        else $error("rd_last without rd_valid");

    // error only reported on done, and then only while busy
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out.error) |-> (w_out.done_res && w_out.busy_res))
        else $error("error outside done tick");

    // read bytes are sampled with scl high during a transaction
    a_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out.rd_valid) |-> (w_out.scl && w_out.busy_res))
        else $error("read byte outside scl high");

endmodule

bind i2c_register_master irm_checker u_irm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/tb.sv]
// self-checking testbench for the i2c register master: directed and random bus tick streams
module tb
    import irm_pkg::*;
();

    // busy ticks the random part runs for, and cycles with no word moving before giving up
    localparam int RANDOM_TICKS = 560;
    localparam int STALL_LIMIT  = 1000;

    // one expected result word: line levels and flags in tdata, burst end in tlast
    typedef struct packed {
        t_out_word lines;
        logic      last;
    } t_line_exp;

    // one directed transaction
    typedef struct packed {
        int         timeout;    // ack_timeout to write first, -1 keeps it
        logic       func;
        logic [7:0] dev;
        logic [7:0] reg_a;
        logic [7:0] data;
        logic [7:0] burst;
        int         nack_byte;  // address/data byte left unacknowledged, -1 for none
        logic [7:0] rd_pattern; // byte the device returns on every read
        int         err_exp;    // error on the done tick, -1 leaves it to the model
    } t_txn_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_we = 1'b0;
    logic [15:0]            i_cfg_wdata = '0;

    i2c_register_master u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // bus sequencer model: its own copy of the state and of ack_timeout
    // ------------------------------------------------------------------
    t_phase      ph        = PH_IDLE;
    logic [3:0]  bit_cnt   = '0;
    logic [7:0]  shreg     = '0;
    logic [7:0]  left      = '0;   // read bytes still to come, this one included
    logic [15:0] wait_cnt  = '0;   // high sda samples seen in the current ack slot
    logic        hold_func = 1'b0;
    logic [7:0]  hold_dev  = '0;
    logic [7:0]  hold_reg  = '0;
    logic [7:0]  hold_data = '0;
    logic [1:0]  byte_sel  = BYTE_DEV;
    logic        err_flag  = 1'b0;
    logic [15:0] ack_lim   = ACK_TIMEOUT_RST;

    // expected result words in order of their input words
    t_line_exp pending_lines [$];

    int n_fail     = 0;
    int n_results  = 0;
    int busy_ticks = 0;
    int n_writes   = 0;
    int n_reads    = 0;
    int n_abort    = 0;
    int n_bytes    = 0;
    int src_cnt    = 0;
    bit src_calm   = 1'b0;
    bit sink_calm  = 1'b0;
    int stall_cycles = 0;

    // a zero register behaves as one
    function automatic logic [15:0] eff_timeout();
        return (ack_lim == 16'd0) ? 16'd1 : ack_lim;
    endfunction

    function automatic void load_tx_byte(input logic [7:0] b, input logic [1:0] sel);
        shreg    = b;
        bit_cnt  = '0;
        byte_sel = sel;
        ph       = PH_WLOW;
    endfunction

    // line levels and flags for one tick, stepping the model state
    function automatic t_line_exp next_bus_levels(input t_in_word w);
        t_line_exp e;
        e = '0;
        e.lines.scl      = 1'b1;
        e.lines.sda_out  = 1'b1;
        e.lines.busy_res = 1'b1;
        case (ph)
            PH_IDLE: begin
                e.lines.busy_res = 1'b0;
                if (w.start_req) begin
                    hold_func = w.func;
                    hold_dev  = w.slave_addr;
                    hold_reg  = w.sub_addr;
                    hold_data = w.wr_data;
                    // a zero length reads one byte
                    left      = (w.burst_len == 8'd0) ? 8'd1 : w.burst_len;
                    err_flag  = 1'b0;
                    e.lines.busy_res = 1'b1;
                    e.lines.sda_out  = 1'b0;
                    ph = PH_START2;
                end
            end
            PH_START2: begin
                e.lines.scl     = 1'b0;
                e.lines.sda_out = 1'b0;
                load_tx_byte(hold_dev, BYTE_DEV);
            end
            PH_WLOW: begin
                e.lines.scl     = 1'b0;
                e.lines.sda_out = shreg[7];
                ph = PH_WHIGH;
            end
            PH_WHIGH: begin
                e.lines.sda_out = shreg[7];
                shreg   = shreg << 1;
                bit_cnt = bit_cnt + 4'd1;
                ph = (bit_cnt >= 4'd8) ? PH_ALOW : PH_WLOW;
            end
            PH_ALOW: begin
                e.lines.scl = 1'b0;
                wait_cnt = '0;
                ph = PH_AHIGH;
            end
            PH_AHIGH: begin
                if (!w.sda_in) begin
                    case (byte_sel)
                        BYTE_DEV: load_tx_byte(hold_reg, BYTE_REG);
                        BYTE_REG: begin
                            if (hold_func == FUNC_READ) ph = PH_RS1;
                            else load_tx_byte(hold_data, BYTE_DATA);
                        end
                        default: begin
                            if (hold_func == FUNC_READ) begin
                                shreg   = '0;
                                bit_cnt = '0;
                                ph = PH_RLOW;
                            end else begin
                                ph = PH_STOP1;
                            end
                        end
                    endcase
                end else begin
                    wait_cnt = wait_cnt + 16'd1;
                    if (wait_cnt >= eff_timeout() || wait_cnt == 16'd0) begin
                        err_flag = 1'b1;
                        ph = PH_STOP1;
                    end
                end
            end
            PH_RS1: begin
                e.lines.scl = 1'b0;
                ph = PH_RS2;
            end
            PH_RS2: ph = PH_RS3;
            PH_RS3: begin
                e.lines.sda_out = 1'b0;
                ph = PH_RS4;
            end
            PH_RS4: begin
                e.lines.scl     = 1'b0;
                e.lines.sda_out = 1'b0;
                load_tx_byte(hold_dev + 8'd1, BYTE_DATA);
            end
            PH_RLOW: begin
                e.lines.scl = 1'b0;
                ph = PH_RHIGH;
            end
            PH_RHIGH: begin
                shreg   = {shreg[6:0], w.sda_in};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                    e.lines.rd_valid = 1'b1;
                    e.lines.rd_data  = shreg;
                    e.last = (left <= 8'd1);
                    ph = PH_MLOW;
                end else begin
                    ph = PH_RLOW;
                end
            end
            PH_MLOW: begin
                e.lines.scl     = 1'b0;
                e.lines.sda_out = (left <= 8'd1);
                ph = PH_MHIGH;
            end
            PH_MHIGH: begin
                e.lines.sda_out = (left <= 8'd1);
                if (left <= 8'd1) begin
                    ph = PH_STOP1;
                end else begin
                    left    = left - 8'd1;
                    shreg   = '0;
                    bit_cnt = '0;
                    ph = PH_RLOW;
                end
            end
            PH_STOP1: begin
                e.lines.scl     = 1'b0;
                e.lines.sda_out = 1'b0;
                ph = PH_STOP2;
            end
            PH_STOP2: begin
                e.lines.sda_out = 1'b0;
                ph = PH_STOP3;
            end
            PH_STOP3: begin
                e.lines.done_res = 1'b1;
                e.lines.error    = err_flag;
                err_flag = 1'b0;
                ph = PH_IDLE;
            end
            default: begin
                e.lines.busy_res = 1'b0;
                ph = PH_IDLE;
            end
        endcase
        return e;
    endfunction

    // ------------------------------------------------------------------
    // result side: random tready, compare each taken word with the oldest expectation
    // ------------------------------------------------------------------
    function automatic void cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_out_word got;
        t_line_exp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[13:0];
            n_results++;
            if (pending_lines.size() == 0) begin
                $display("%0t: result word %h with nothing expected", $time, m_axis_tdata);
                n_fail++;
            end else begin
                want = pending_lines.pop_front();
                cmp_field("scl", int'(want.lines.scl), int'(got.scl));
                cmp_field("sda_out", int'(want.lines.sda_out), int'(got.sda_out));
                cmp_field("busy_res", int'(want.lines.busy_res), int'(got.busy_res));
                cmp_field("rd_valid", int'(want.lines.rd_valid), int'(got.rd_valid));
                cmp_field("rd_data", int'(want.lines.rd_data), int'(got.rd_data));
                cmp_field("done_res", int'(want.lines.done_res), int'(got.done_res));
                cmp_field("error", int'(want.lines.error), int'(got.error));
                cmp_field("rd_last", int'(want.last), int'(m_axis_tlast));
            end
        end
    end

    // stalls drawn per word, with calm stretches where tready stays up
    initial begin : result_sink
        int gap;
        int cnt;
        cnt = 0;
        @(posedge i_rst_n);
        forever begin
            if (cnt % 50 == 0) sink_calm = ($urandom_range(0, 3) == 0);
            cnt++;
            gap = sink_calm ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // watchdog: any cycle where a word moves on either side restarts the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    function automatic t_in_word random_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_word)-1:0];
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken;
    // typed_err >= 0 replaces the model's done word with a fixed one
    task automatic send_word(input t_in_word w, input int typed_err);
        int gap;
        t_line_exp e;
        if (src_cnt % 50 == 0) src_calm = ($urandom_range(0, 3) == 0);
        src_cnt++;
        gap = src_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - $bits(t_in_word)){1'b0}}, w};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (ph != PH_IDLE || w.start_req) busy_ticks++;
        e = next_bus_levels(w);
        if (e.lines.rd_valid) n_bytes++;
        if (e.lines.done_res && e.lines.error) n_abort++;
        if (typed_err >= 0) begin
            // stop released, done with the given error, nothing read
            e = '0;
            e.lines.scl      = 1'b1;
            e.lines.sda_out  = 1'b1;
            e.lines.busy_res = 1'b1;
            e.lines.done_res = 1'b1;
            e.lines.error    = typed_err[0];
        end
        pending_lines.push_back(e);
        @(negedge i_clk);
    endtask

    // drain every expected word, let the pipeline settle, then write the register
    task automatic set_ack_timeout(input logic [15:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_lines.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ack_lim = v;
    endtask

    // one whole transaction: up to two idle ticks, the command tick, then ticks until
    // the model is idle again. the device answers in the ack slots, except on the
    // byte picked to go unacknowledged; everything else on the word is noise,
    // including start requests that the busy block must ignore
    task automatic run_txn(input logic func, input logic [7:0] dev, input logic [7:0] reg_a,
                           input logic [7:0] data, input logic [7:0] burst,
                           input int nack_byte, input logic use_pat,
                           input logic [7:0] pat, input int err_exp);
        t_in_word w;
        int idle_n;
        idle_n = $urandom_range(0, 2);
        repeat (idle_n) begin
            w = random_word();
            w.start_req = 1'b0;
            send_word(w, -1);
        end
        w = random_word();
        w.start_req  = 1'b1;
        w.func       = func;
        w.slave_addr = dev;
        w.sub_addr   = reg_a;
        w.wr_data    = data;
        w.burst_len  = burst;
        if (func == FUNC_READ) n_reads++;
        else n_writes++;
        send_word(w, -1);
        while (ph != PH_IDLE) begin
            w = random_word();
            case (ph)
                PH_AHIGH: begin
                    if (int'(byte_sel) == nack_byte) begin
                        w.sda_in = 1'b1;
                    end else begin
                        // a late acknowledge now and then, always inside the limit
                        w.sda_in = (({1'b0, wait_cnt} + 17'd1) < {1'b0, eff_timeout()})
                                   && ($urandom_range(0, 3) == 0);
                    end
                end
                PH_RHIGH: begin
                    if (use_pat) w.sda_in = pat[3'd7 - bit_cnt[2:0]];
                end
                default: ;
            endcase
            send_word(w, (ph == PH_STOP3) ? err_exp : -1);
        end
    endtask

    // directed transactions: extremes of every byte field, both operations, address
    // wrap on the read address, zero burst length, zero and extreme timeouts, and a
    // missing acknowledge on each byte of a write and on the second and third byte of a read
    t_txn_row dir_rows [12] = '{
        '{-1,    FUNC_WRITE, 8'h00, 8'h00, 8'h00, 8'd1,   -1, 8'h00, 0},
        '{-1,    FUNC_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'd1,   -1, 8'h00, 0},
        '{-1,    FUNC_READ,  8'hA0, 8'h10, 8'h00, 8'd1,   -1, 8'h00, 0},
        '{-1,    FUNC_READ,  8'hFF, 8'h5A, 8'h33, 8'd3,   -1, 8'hFF, 0},
        '{-1,    FUNC_READ,  8'h42, 8'hC3, 8'h00, 8'd0,   -1, 8'hA5, 0},
        '{1,     FUNC_WRITE, 8'h3C, 8'h01, 8'h80, 8'd1,   0,  8'h00, 1},
        '{0,     FUNC_WRITE, 8'h3C, 8'h02, 8'h7F, 8'd1,   1,  8'h00, 1},
        '{3,     FUNC_WRITE, 8'h3C, 8'h03, 8'h55, 8'd1,   2,  8'h00, 1},
        '{2,     FUNC_READ,  8'h90, 8'h04, 8'h00, 8'd255, 2,  8'h00, 1},
        '{2,     FUNC_READ,  8'h90, 8'h05, 8'h00, 8'd128, 1,  8'h00, 1},
        '{65535, FUNC_READ,  8'h6E, 8'h80, 8'h00, 8'd2,   -1, 8'h3C, 0},
        '{7,     FUNC_WRITE, 8'h55, 8'hAA, 8'h69, 8'd1,   -1, 8'h00, 0}
    };

    initial begin : stimulus
        t_txn_row    row;
        int          target;
        int          n_rand;
        int          nack;
        logic        func;
        logic [7:0]  burst;
        logic [15:0] to;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.timeout >= 0) set_ack_timeout(row.timeout[15:0]);
            run_txn(row.func, row.dev, row.reg_a, row.data, row.burst, row.nack_byte,
                    1'b1, row.rd_pattern, row.err_exp);
        end

        // random transactions; the timeout changes every few of them, and missing
        // acknowledges are only drawn while the timeout is short
        target = busy_ticks + RANDOM_TICKS;
        n_rand = 0;
        while (busy_ticks < target) begin
            if (n_rand % 6 == 0) begin
                case ($urandom_range(0, 4))
                    0: to = 16'd1;
                    1: to = 16'($urandom_range(2, 8));
                    2: to = ACK_TIMEOUT_RST;
                    3: to = 16'hFFFF;
                    default: to = 16'($urandom_range(1, 65535));
                endcase
                set_ack_timeout(to);
            end
            n_rand++;
            func = 1'($urandom_range(0, 1));
            nack = -1;
            if (eff_timeout() <= 16'd8 && $urandom_range(0, 3) == 0) begin
                nack = int'($urandom_range(0, 2));
            end
            burst = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(5, 16))
                                                : 8'($urandom_range(1, 4));
            // aborted reads never reach the data, so any length is cheap there
            if (nack >= 0) burst = 8'($urandom_range(0, 255));
            run_txn(func, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), burst, nack, 1'b0, 8'h00, -1);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_lines.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("ran %0d register writes and %0d burst reads, %0d ended on a missing ack",
                 n_writes, n_reads, n_abort);
        $display("%0d bytes read back, %0d result words compared", n_bytes, n_results);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
